// ===== rtl/glm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glm_pkg
// Types and constants shared by the gated loudness meter.
// ----------------------------------------------------------------------------
package glm_pkg;

    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_FINISH = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic signed [13:0] LOUD_MIN = -14'sd7000;
    localparam logic signed [13:0] LOUD_MAX = 14'sd600;
    localparam logic [31:0] ABS_GATE_MIN = 32'd32;
    localparam logic [24:0] LOG_SCALE = 25'd19728302;
    localparam logic signed [63:0] LOG_OFFSET = 64'sd296782240154;

    typedef enum logic [1:0] {
        DIV_SHORT = 2'd0,
        DIV_WIN   = 2'd1,
        DIV_GATE  = 2'd2
    } div_sel_t;

    typedef struct packed {
        logic     push;
        logic     clear;
        logic     div_start;
        div_sel_t div_sel;
        logic     log_start;
        logic     short_load;
        logic     block_write;
        logic     scan_start;
        logic     scan_pass2;
        logic     ungated_load;
        logic     out_load;
        logic     out_finish;
        logic     out_use_ungated;
        logic     out_min;
    } glm_cmd_t;

    typedef struct packed {
        logic div_done;
        logic log_done;
        logic scan_done;
        logic window_full;
        logic hist_empty;
        logic acount_zero;
        logic gcount_zero;
    } glm_stat_t;

endpackage
`default_nettype wire

// ===== rtl/glm_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glm_stream_if
// Valid/ready channel carrying one word of width W.
// ----------------------------------------------------------------------------
interface glm_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/glm_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glm_divider
// Restoring divider, one quotient bit per cycle; quotient truncated to 32 bits.
// ----------------------------------------------------------------------------
module glm_divider #(
    parameter int NW = 48,
    parameter int DW = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [31:0]        quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [DW:0]   trial;
    logic [DW:0]   rs;

    always_comb
    begin
        rs    = {r_reg[DW-1:0], q_reg[NW-1]};
        trial = rs - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!trial[DW])
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= rs;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign quot = q_reg[31:0];
endmodule
`default_nettype wire

// ===== rtl/glm_log_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glm_log_unit
// Loudness in hundredths of LUFS: log2 by repeated squaring, one bit a cycle.
// ----------------------------------------------------------------------------
module glm_log_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [31:0]        p,
    output logic                    done,
    output logic signed [13:0]      loud
);
    import glm_pkg::*;

    typedef enum logic [4:0] {
        LG_IDLE = 5'b00001,
        LG_NORM = 5'b00010,
        LG_SQ   = 5'b00100,
        LG_MUL  = 5'b01000,
        LG_FIN  = 5'b10000
    } lg_state_t;

    lg_state_t     state_reg;
    logic [31:0]   m_reg;
    logic [4:0]    e_reg;
    logic [15:0]   frac_reg;
    logic [4:0]    cnt_reg;
    logic          zero_reg;
    logic signed [63:0] v_reg;
    logic [63:0]   sq;
    logic [32:0]   msh;
    logic [4:0]    msb;
    logic signed [22:0] l2;
    logic signed [63:0] u;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < 32; i++)
            if (m_reg[i]) msb = 5'(i);
    end

    assign sq  = {32'd0, m_reg} * {32'd0, m_reg};
    assign msh = sq[63:31];
    assign l2  = 23'(($signed({1'b0, e_reg}) - 6'sd28)) * 23'sd65536
                 + $signed({7'd0, frac_reg});
    assign u   = (v_reg + 64'sd70368744177664 + 64'sd2147483648) >>> 32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LG_IDLE;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                LG_IDLE: if (start) state_reg <= LG_NORM;
                LG_NORM: state_reg <= zero_reg ? LG_FIN : LG_SQ;
                LG_SQ:   if (cnt_reg == 5'd15) state_reg <= LG_MUL;
                LG_MUL:  state_reg <= LG_FIN;
                LG_FIN:
                begin
                    state_reg <= LG_IDLE;
                    done      <= 1'b1;
                end
                default: state_reg <= LG_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            LG_IDLE:
                if (start)
                begin
                    m_reg    <= p;
                    zero_reg <= (p == 32'd0);
                    frac_reg <= '0;
                    cnt_reg  <= '0;
                end
            LG_NORM:
            begin
                e_reg <= msb;
                m_reg <= m_reg << (5'd31 - msb);
            end
            LG_SQ:
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (msh[32])
                begin
                    frac_reg <= {frac_reg[14:0], 1'b1};
                    m_reg    <= msh[32:1];
                end
                else
                begin
                    frac_reg <= {frac_reg[14:0], 1'b0};
                    m_reg    <= msh[31:0];
                end
            end
            LG_MUL:
                v_reg <= 64'(l2) * $signed({39'd0, LOG_SCALE}) - LOG_OFFSET;
            LG_FIN:
                if (zero_reg) loud <= LOUD_MIN;
                else if (u - 64'sd16384 < 64'(LOUD_MIN)) loud <= LOUD_MIN;
                else if (u - 64'sd16384 > 64'(LOUD_MAX)) loud <= LOUD_MAX;
                else loud <= 14'(u - 64'sd16384);
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/glm_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glm_datapath
// Rings, sums, block history, gating scan, divider and log unit.
// ----------------------------------------------------------------------------
module glm_datapath #(
    parameter int SHORT_STEPS    = 30,
    parameter int WINDOW_STEPS   = 4,
    parameter int HISTORY_BLOCKS = 16384
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire glm_pkg::glm_cmd_t    cmd,
    output glm_pkg::glm_stat_t        stat,
    input  wire logic [31:0]          step_power,
    output logic signed [13:0]        short_term_loudness,
    output logic signed [13:0]        integrated_loudness,
    output logic                      integrated_valid,
    output logic [$clog2(HISTORY_BLOCKS+1)-1:0] blocks_stored
);
    import glm_pkg::*;

    localparam int SPW = (SHORT_STEPS > 1) ? $clog2(SHORT_STEPS) : 1;
    localparam int SFW = $clog2(SHORT_STEPS + 1);
    localparam int WPW = (WINDOW_STEPS > 1) ? $clog2(WINDOW_STEPS) : 1;
    localparam int WFW = $clog2(WINDOW_STEPS + 1);
    localparam int HPW = $clog2(HISTORY_BLOCKS);
    localparam int HFW = $clog2(HISTORY_BLOCKS + 1);
    localparam int SSW = 32 + SFW;
    localparam int WSW = 32 + WFW;
    localparam int GSW = 32 + HFW;
    localparam int DNW = GSW;
    localparam int DDW = HFW;
    localparam int WL  = (WINDOW_STEPS > 1) ? $clog2(WINDOW_STEPS) : 0;
    localparam int WSH = WSW + WL;
    localparam int WMW = WSW + 1;
    localparam int WAW = 48 + WMW;
    localparam logic [WMW-1:0] WRECIP =
        WMW'(((64'd1 << WSH) + 64'(WINDOW_STEPS) - 64'd1) / 64'(WINDOW_STEPS));

    logic [31:0] short_ring [SHORT_STEPS];
    logic [31:0] window_ring [WINDOW_STEPS];
    logic [31:0] hist [HISTORY_BLOCKS];

    logic [SSW-1:0] short_sum_reg;
    logic [SFW-1:0] short_fill_reg;
    logic [SPW-1:0] short_pos_reg;
    logic [WSW-1:0] window_sum_reg;
    logic [WFW-1:0] window_fill_reg;
    logic [WPW-1:0] window_pos_reg;
    logic [HFW-1:0] block_fill_reg;
    logic [HPW-1:0] block_pos_reg;
    logic signed [13:0] short_loud_reg;
    logic [31:0]    block_reg;

    logic [GSW-1:0] asum_reg, gsum_reg;
    logic [HFW-1:0] acount_reg, gcount_reg;
    logic           pass2_reg;
    logic           scan_busy_reg, scan_valid_reg, scan_done_reg;
    logic [HFW-1:0] scan_idx_reg;
    logic [31:0]    rd_reg;
    logic [31:0]    mult_p_reg;
    logic           mult_v_reg;
    logic [GSW+3:0] mult_reg;
    logic signed [13:0] ungated_reg;

    logic           dstart;
    logic [DNW-1:0] dnum;
    logic [DDW-1:0] dden;
    logic           ddone;
    logic [31:0]    dquot;
    logic           ldone;
    logic signed [13:0] lres;

    logic              wstart;
    logic              wbusy_reg, wdone_reg;
    logic [1:0]        wcnt_reg;
    logic [47:0]       wx_reg;
    logic [WAW-1:0]    wacc_reg;
    logic [16+WMW-1:0] wpp;

    logic [SSW-1:0] ss_next;
    logic [WSW-1:0] ws_next;
    logic [31:0]    old_s, old_w;

    always_comb
    begin
        old_s = (short_fill_reg == SFW'(SHORT_STEPS)) ? short_ring[short_pos_reg] : 32'd0;
        old_w = (window_fill_reg == WFW'(WINDOW_STEPS)) ? window_ring[window_pos_reg] : 32'd0;
        ss_next = short_sum_reg - SSW'(old_s) + SSW'(step_power);
        ws_next = window_sum_reg - WSW'(old_w) + WSW'(step_power);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            short_ring[short_pos_reg]   <= step_power;
            window_ring[window_pos_reg] <= step_power;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_sum_reg   <= '0;
            short_fill_reg  <= '0;
            short_pos_reg   <= '0;
            window_sum_reg  <= '0;
            window_fill_reg <= '0;
            window_pos_reg  <= '0;
            block_fill_reg  <= '0;
            block_pos_reg   <= '0;
            short_loud_reg  <= LOUD_MIN;
        end
        else if (cmd.clear)
        begin
            short_sum_reg   <= '0;
            short_fill_reg  <= '0;
            short_pos_reg   <= '0;
            window_sum_reg  <= '0;
            window_fill_reg <= '0;
            window_pos_reg  <= '0;
            block_fill_reg  <= '0;
            block_pos_reg   <= '0;
            short_loud_reg  <= LOUD_MIN;
        end
        else
        begin
            if (cmd.push)
            begin
                short_sum_reg  <= ss_next;
                window_sum_reg <= ws_next;
                if (short_fill_reg != SFW'(SHORT_STEPS))
                    short_fill_reg <= short_fill_reg + 1'b1;
                if (window_fill_reg != WFW'(WINDOW_STEPS))
                    window_fill_reg <= window_fill_reg + 1'b1;
                short_pos_reg <= (short_pos_reg == SPW'(SHORT_STEPS - 1)) ?
                                 '0 : short_pos_reg + 1'b1;
                window_pos_reg <= (window_pos_reg == WPW'(WINDOW_STEPS - 1)) ?
                                  '0 : window_pos_reg + 1'b1;
            end
            if (cmd.block_write)
            begin
                block_pos_reg <= (block_pos_reg == HPW'(HISTORY_BLOCKS - 1)) ?
                                 '0 : block_pos_reg + 1'b1;
                if (block_fill_reg != HFW'(HISTORY_BLOCKS))
                    block_fill_reg <= block_fill_reg + 1'b1;
            end
            if (cmd.short_load)
                short_loud_reg <= lres;
        end
    end

    // window mean by reciprocal multiply, 16 bits of the sum per cycle
    assign wstart = cmd.div_start && (cmd.div_sel == DIV_WIN);
    assign wpp    = (16+WMW)'(wx_reg[47:32]) * (16+WMW)'(WRECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wbusy_reg <= 1'b0;
            wcnt_reg  <= '0;
            wdone_reg <= 1'b0;
        end
        else
        begin
            wdone_reg <= 1'b0;
            if (wstart)
            begin
                wbusy_reg <= 1'b1;
                wcnt_reg  <= 2'd3;
            end
            else if (wbusy_reg)
            begin
                wcnt_reg <= wcnt_reg - 1'b1;
                if (wcnt_reg == 2'd1)
                begin
                    wbusy_reg <= 1'b0;
                    wdone_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wstart)
        begin
            wx_reg   <= 48'(window_sum_reg);
            wacc_reg <= '0;
        end
        else if (wbusy_reg)
        begin
            wacc_reg <= (wacc_reg << 16) + WAW'(wpp);
            wx_reg   <= {wx_reg[31:0], 16'd0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wdone_reg)
            block_reg <= wacc_reg[WSH +: 32];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.block_write)
            hist[block_pos_reg] <= block_reg;
        rd_reg <= hist[scan_idx_reg[HPW-1:0]];
    end

    // scan: read, then multiply, then accumulate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_busy_reg  <= 1'b0;
            scan_valid_reg <= 1'b0;
            mult_v_reg     <= 1'b0;
            scan_done_reg  <= 1'b0;
            scan_idx_reg   <= '0;
        end
        else
        begin
            scan_done_reg  <= 1'b0;
            scan_valid_reg <= scan_busy_reg;
            mult_v_reg     <= scan_valid_reg;
            if (cmd.scan_start)
            begin
                scan_busy_reg <= 1'b1;
                scan_idx_reg  <= '0;
            end
            else if (scan_busy_reg)
            begin
                if (scan_idx_reg == block_fill_reg - 1'b1)
                    scan_busy_reg <= 1'b0;
                else
                    scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (!scan_busy_reg && !scan_valid_reg && mult_v_reg)
                scan_done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            pass2_reg <= cmd.scan_pass2;
            gsum_reg  <= '0;
            gcount_reg <= '0;
            if (!cmd.scan_pass2)
            begin
                asum_reg   <= '0;
                acount_reg <= '0;
            end
        end
        else
        begin
            if (scan_valid_reg)
            begin
                mult_p_reg <= rd_reg;
                mult_reg   <= (GSW+4)'(rd_reg) * (GSW+4)'(acount_reg) * (GSW+4)'(10);
            end
            if (mult_v_reg && mult_p_reg >= ABS_GATE_MIN)
            begin
                if (!pass2_reg)
                begin
                    asum_reg   <= asum_reg + GSW'(mult_p_reg);
                    acount_reg <= acount_reg + 1'b1;
                end
                else if (mult_reg > (GSW+4)'(asum_reg))
                begin
                    gsum_reg   <= gsum_reg + GSW'(mult_p_reg);
                    gcount_reg <= gcount_reg + 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        case (cmd.div_sel)
            DIV_SHORT:
            begin
                dnum = DNW'(ss_next);
                dden = DDW'(short_fill_reg);
            end
            DIV_WIN:
            begin
                dnum = DNW'(window_sum_reg);
                dden = DDW'(WINDOW_STEPS);
            end
            default:
            begin
                dnum = pass2_reg ? gsum_reg : asum_reg;
                dden = pass2_reg ? gcount_reg : acount_reg;
            end
        endcase
    end

    // short mean uses the sum registered after the push
    logic [DNW-1:0] dnum_sel;
    assign dnum_sel = (cmd.div_sel == DIV_SHORT) ? DNW'(short_sum_reg) : dnum;
    assign dstart   = cmd.div_start && (cmd.div_sel != DIV_WIN);

    glm_divider #(.NW(DNW), .DW(DDW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dstart), .num(dnum_sel), .den(dden),
        .done(ddone), .quot(dquot)
    );

    glm_log_unit u_log (
        .clk(clk), .rst_n(rst_n), .start(cmd.log_start), .p(dquot),
        .done(ldone), .loud(lres)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.ungated_load)
            ungated_reg <= lres;
        if (cmd.out_load)
        begin
            integrated_valid <= cmd.out_finish;
            if (!cmd.out_finish)
                integrated_loudness <= '0;
            else if (cmd.out_min)
                integrated_loudness <= LOUD_MIN;
            else if (cmd.out_use_ungated)
                integrated_loudness <= ungated_reg;
            else
                integrated_loudness <= lres;
        end
    end

    assign short_term_loudness = short_loud_reg;
    assign blocks_stored       = block_fill_reg;

    assign stat.div_done    = ddone || wdone_reg;
    assign stat.log_done    = ldone;
    assign stat.scan_done   = scan_done_reg;
    assign stat.window_full = (window_fill_reg == WFW'(WINDOW_STEPS));
    assign stat.hist_empty  = (block_fill_reg == '0);
    assign stat.acount_zero = (acount_reg == '0);
    assign stat.gcount_zero = (gcount_reg == '0);
endmodule
`default_nettype wire

// ===== rtl/glm_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// glm_controller
// Sequencer for push, finish and clear commands.
// ----------------------------------------------------------------------------
module glm_controller (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [1:0]         command,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output glm_pkg::glm_cmd_t       cmd,
    input  wire glm_pkg::glm_stat_t stat
);
    import glm_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_SDIV  = 12'b000000000010,
        S_SLOG  = 12'b000000000100,
        S_WDIV  = 12'b000000001000,
        S_WWR   = 12'b000000010000,
        S_SCAN1 = 12'b000000100000,
        S_ADIV  = 12'b000001000000,
        S_ALOG  = 12'b000010000000,
        S_SCAN2 = 12'b000100000000,
        S_GDIV  = 12'b001000000000,
        S_GLOG  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } ctl_state_t;

    ctl_state_t state_reg, state_next;
    logic out_valid_next;
    logic acc;

    assign in_ready = (state_reg == S_IDLE) && (!out_valid || out_ready);
    assign acc      = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.div_sel    = DIV_SHORT;
        out_valid_next = out_valid && !out_ready;
        case (state_reg)
            S_IDLE:
                if (acc)
                begin
                    case (command)
                        CMD_PUSH:
                        begin
                            cmd.push   = 1'b1;
                            state_next = S_SDIV;
                        end
                        CMD_FINISH:
                        begin
                            if (stat.hist_empty)
                            begin
                                cmd.out_load   = 1'b1;
                                cmd.out_finish = 1'b1;
                                cmd.out_min    = 1'b1;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_SCAN1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            cmd.clear      = 1'b1;
                            cmd.out_load   = 1'b1;
                            out_valid_next = 1'b1;
                        end
                        default:
                        begin
                            cmd.out_load   = 1'b1;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            S_SDIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_SLOG;
            end
            S_SLOG:
            begin
                cmd.log_start = stat.div_done;
                if (stat.log_done)
                begin
                    cmd.short_load = 1'b1;
                    if (stat.window_full)
                    begin
                        cmd.div_sel   = DIV_WIN;
                        cmd.div_start = 1'b1;
                        state_next    = S_WDIV;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_WDIV:
            begin
                cmd.div_sel = DIV_WIN;
                if (stat.div_done) state_next = S_WWR;
            end
            S_WWR:
            begin
                cmd.block_write = 1'b1;
                state_next      = S_OUT;
            end
            S_SCAN1:
                if (stat.scan_done)
                begin
                    if (stat.acount_zero)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_finish = 1'b1;
                        cmd.out_min    = 1'b1;
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.div_sel   = DIV_GATE;
                        cmd.div_start = 1'b1;
                        state_next    = S_ADIV;
                    end
                end
            S_ADIV:
            begin
                cmd.div_sel   = DIV_GATE;
                cmd.log_start = stat.div_done;
                if (stat.div_done) state_next = S_ALOG;
            end
            S_ALOG:
                if (stat.log_done)
                begin
                    cmd.ungated_load = 1'b1;
                    cmd.scan_start   = 1'b1;
                    cmd.scan_pass2   = 1'b1;
                    state_next       = S_SCAN2;
                end
            S_SCAN2:
                if (stat.scan_done)
                begin
                    if (stat.gcount_zero)
                    begin
                        cmd.out_load        = 1'b1;
                        cmd.out_finish      = 1'b1;
                        cmd.out_use_ungated = 1'b1;
                        out_valid_next      = 1'b1;
                        state_next          = S_IDLE;
                    end
                    else
                    begin
                        cmd.div_sel   = DIV_GATE;
                        cmd.div_start = 1'b1;
                        state_next    = S_GDIV;
                    end
                end
            S_GDIV:
            begin
                cmd.div_sel   = DIV_GATE;
                cmd.log_start = stat.div_done;
                if (stat.div_done) state_next = S_GLOG;
            end
            S_GLOG:
                if (stat.log_done)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            S_OUT:
                if (!out_valid || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("input accepted while busy");
    a_push_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && command == CMD_PUSH) |=> (state_reg == S_SDIV))
        else $error("push did not start short mean");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

// ===== rtl/gated_loudness_meter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gated_loudness_meter
// Short-term and gated integrated loudness from 100 ms step powers.
// ----------------------------------------------------------------------------
// Push: the result follows a serial mean divide and a log, and once the block
// window is full also a window mean multiply and a history write.
// Finish: up to two history scans, with a divide and a log after each as needed.
// Clear and unused codes: result word valid in the cycle after accept.
// One word in flight; the result register frees the input once taken.
// rst_n clears all control state asynchronously; no memory clearing pass.
module gated_loudness_meter #(
    parameter int SHORT_STEPS    = 30,
    parameter int WINDOW_STEPS   = 4,
    parameter int HISTORY_BLOCKS = 16384
) (
    input wire logic clk,
    input wire logic rst_n,
    glm_stream_if.sink   in_ch,
    glm_stream_if.source out_ch
);
    import glm_pkg::*;

    localparam int HFW = $clog2(HISTORY_BLOCKS + 1);

    glm_cmd_t  cmd;
    glm_stat_t stat;
    logic signed [13:0] st_l, in_l;
    logic       iv;
    logic [HFW-1:0] bs;

    glm_controller u_ctl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .command(in_ch.data[1:0]), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
        .cmd(cmd), .stat(stat)
    );

    glm_datapath #(
        .SHORT_STEPS(SHORT_STEPS), .WINDOW_STEPS(WINDOW_STEPS),
        .HISTORY_BLOCKS(HISTORY_BLOCKS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .step_power(in_ch.data[33:2]),
        .short_term_loudness(st_l), .integrated_loudness(in_l),
        .integrated_valid(iv), .blocks_stored(bs)
    );

    logic signed [13:0] st_hold;
    logic [HFW-1:0] bs_hold;
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            st_hold <= cmd.clear ? LOUD_MIN : st_l;
            bs_hold <= cmd.clear ? '0 : bs;
        end
    end

    assign out_ch.data = {15'(bs_hold), iv, in_l, st_hold};
endmodule
`default_nettype wire

// ===== tb/tb_gated_loudness_meter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gated_loudness_meter
// Drives push, finish, clear and unused command words into the meter with
// random sender gaps and receiver stalls. A scoreboard keeps its own copy of
// the short-term ring, the block window and the block history, predicts each
// result word and compares it field by field with what the meter returns.
// ----------------------------------------------------------------------------
module tb_gated_loudness_meter;
    import glm_pkg::*;

    localparam int SHORT_STEPS    = 30;
    localparam int WINDOW_STEPS   = 4;
    localparam int HISTORY_BLOCKS = 16384;
    localparam int IN_W           = 34;
    localparam int OUT_W          = 44;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic signed [13:0] short_loud;
        logic signed [13:0] integ_loud;
        logic               integ_valid;
        logic [14:0]        blocks;
    } meter_word_t;

    class loudness_scoreboard;
        int unsigned short_ring [SHORT_STEPS];
        longint unsigned short_sum;
        int unsigned short_fill, short_pos;
        logic signed [13:0] short_loud;
        int unsigned win_ring [WINDOW_STEPS];
        longint unsigned win_sum;
        int unsigned win_fill, win_pos;
        int unsigned history [HISTORY_BLOCKS];
        int unsigned block_fill, block_pos;
        meter_word_t pending [$];
        int errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            short_sum = 0; short_fill = 0; short_pos = 0; short_loud = LOUD_MIN;
            win_sum = 0; win_fill = 0; win_pos = 0;
            block_fill = 0; block_pos = 0;
        endfunction

        function logic signed [13:0] loudness(logic [31:0] p);
            int e;
            longint unsigned m, u;
            longint l2, v, h;
            int unsigned frac;
            if (p == 0)
                return LOUD_MIN;
            e = 31;
            while (p[e] == 1'b0)
                e--;
            m = longint'(p) << (31 - e);
            frac = 0;
            for (int i = 0; i < 16; i++)
            begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000)
                begin
                    frac = frac | 1;
                    m = m >> 1;
                end
            end
            l2 = longint'(e - 28) * 65536 + longint'(frac);
            v = l2 * longint'(LOG_SCALE) - LOG_OFFSET;
            u = longint'(v + (64'sd1 <<< 46) + (64'sd1 <<< 31)) >> 32;
            h = longint'(u) - 16384;
            if (h < -7000)
                h = -7000;
            if (h > 600)
                h = 600;
            return h[13:0];
        endfunction

        function logic signed [13:0] gated();
            longint unsigned asum, gsum, acount, gcount;
            logic signed [13:0] ungated;
            asum = 0; gsum = 0; acount = 0; gcount = 0;
            if (block_fill == 0)
                return LOUD_MIN;
            for (int i = 0; i < block_fill; i++)
                if (history[i] >= ABS_GATE_MIN)
                begin
                    asum += history[i];
                    acount++;
                end
            if (acount == 0)
                return LOUD_MIN;
            ungated = loudness(32'(asum / acount));
            for (int i = 0; i < block_fill; i++)
                if (history[i] >= ABS_GATE_MIN &&
                    longint'(history[i]) * 10 * acount > asum)
                begin
                    gsum += history[i];
                    gcount++;
                end
            if (gcount == 0)
                return ungated;
            return loudness(32'(gsum / gcount));
        endfunction

        function void push(int unsigned p);
            if (short_fill < SHORT_STEPS)
                short_fill++;
            else
                short_sum -= short_ring[short_pos];
            short_ring[short_pos] = p;
            short_sum += p;
            short_pos = (short_pos + 1) % SHORT_STEPS;
            short_loud = loudness(32'(short_sum / short_fill));
            if (win_fill < WINDOW_STEPS)
                win_fill++;
            else
                win_sum -= win_ring[win_pos];
            win_ring[win_pos] = p;
            win_sum += p;
            win_pos = (win_pos + 1) % WINDOW_STEPS;
            if (win_fill == WINDOW_STEPS)
            begin
                history[block_pos] = 32'(win_sum / WINDOW_STEPS);
                block_pos = (block_pos + 1) % HISTORY_BLOCKS;
                if (block_fill < HISTORY_BLOCKS)
                    block_fill++;
            end
        endfunction

        function void note_word(logic [IN_W-1:0] w);
            meter_word_t x;
            logic [1:0] cmd;
            cmd = w[1:0];
            x.integ_loud = '0;
            x.integ_valid = 1'b0;
            case (cmd)
                CMD_PUSH:   push(w[33:2]);
                CMD_FINISH:
                begin
                    x.integ_loud = gated();
                    x.integ_valid = 1'b1;
                end
                CMD_CLEAR:  clear_state();
                default: ;
            endcase
            x.short_loud = short_loud;
            x.blocks = 15'(block_fill);
            pending.push_back(x);
        endfunction

        function void check_word(logic [OUT_W-1:0] w);
            meter_word_t x;
            if (pending.size() == 0)
            begin
                $error("unexpected result word %h", w);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (w[13:0] !== x.short_loud)
            begin
                $error("short_term_loudness exp %0d act %0d", x.short_loud, $signed(w[13:0]));
                errors++;
            end
            if (w[27:14] !== x.integ_loud)
            begin
                $error("integrated_loudness exp %0d act %0d", x.integ_loud, $signed(w[27:14]));
                errors++;
            end
            if (w[28] !== x.integ_valid)
            begin
                $error("integrated_valid exp %0d act %0d", x.integ_valid, w[28]);
                errors++;
            end
            if (w[43:29] !== x.blocks)
            begin
                $error("blocks_stored exp %0d act %0d", x.blocks, w[43:29]);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    longint cycles = 0;
    int send_idle = 0;
    int recv_stall = 0;
    loudness_scoreboard sb = new();

    glm_stream_if #(.W(IN_W))  in_ch ();
    glm_stream_if #(.W(OUT_W)) out_ch ();

    gated_loudness_meter i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    always #4 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    always @(negedge clk)
        out_ch.ready <= ($urandom_range(99) >= recv_stall);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (in_ch.valid && in_ch.ready)
            sb.note_word(in_ch.data);
        if (out_ch.valid && out_ch.ready)
            sb.check_word(out_ch.data);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_gated_loudness_meter: done, errors");
            $finish;
        end
    end

    task automatic send_word(logic [1:0] cmd, logic [31:0] p);
        while ($urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {p, cmd};
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    function automatic logic [31:0] rand_power();
        int k;
        k = $urandom_range(99);
        if (k < 10)
            return $urandom_range(63);
        if (k < 55)
            return $urandom >> $urandom_range(31);
        return ($urandom >> $urandom_range(10, 4)) | 32'h0100_0000;
    endfunction

    task automatic random_phase(int items);
        int k;
        for (int n = 0; n < items; n++)
        begin
            k = $urandom_range(999);
            if (k < 880)
                send_word(CMD_PUSH, rand_power());
            else if (k < 975)
                send_word(CMD_FINISH, $urandom);
            else if (k < 990)
                send_word(CMD_CLEAR, $urandom);
            else
                send_word(CMD_UNUSED, $urandom);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_word(CMD_FINISH, 32'h0);
        send_word(CMD_PUSH, 32'h0);
        send_word(CMD_FINISH, 32'h0);
        send_word(CMD_PUSH, 32'hFFFF_FFFF);
        send_word(CMD_PUSH, 32'hFFFF_FFFF);
        send_word(CMD_PUSH, 32'hFFFF_FFFF);
        send_word(CMD_FINISH, 32'hFFFF_FFFF);
        send_word(CMD_UNUSED, 32'hFFFF_FFFF);
        send_word(CMD_CLEAR, 32'h0);
        repeat (4) send_word(CMD_PUSH, 32'd31);
        send_word(CMD_FINISH, 32'h0);
        repeat (4) send_word(CMD_PUSH, 32'd32);
        send_word(CMD_FINISH, 32'h0);
        send_word(CMD_PUSH, 32'h1000_0000);
        send_word(CMD_PUSH, 32'h0000_0100);
        send_word(CMD_FINISH, 32'h0);
        send_word(CMD_CLEAR, 32'hFFFF_FFFF);
        drain();

        random_phase(330);
        send_idle = 54; recv_stall = 0;
        random_phase(330);
        send_idle = 0; recv_stall = 54;
        random_phase(330);
        send_idle = 23; recv_stall = 23;
        random_phase(330);
        send_idle = 0; recv_stall = 0;
        drain();
        repeat (100) @(negedge clk);

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_gated_loudness_meter: done, clean");
        else
            $display("tb_gated_loudness_meter: done, errors");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/glm_pkg.sv
rtl/glm_stream_if.sv
rtl/glm_divider.sv
rtl/glm_log_unit.sv
rtl/glm_datapath.sv
rtl/glm_controller.sv
rtl/gated_loudness_meter.sv
tb/tb_gated_loudness_meter.sv
